FILE: src/bss_pkg.sv
// shared constants and types of the bounded stack with search
`default_nettype none
package bss_pkg;

	localparam int DEPTH  = 8;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW     = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;
	localparam int POS_W  = 3;

	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_LIST   = 2'd2,
		OP_SEARCH = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_PUSHED     = 3'd0,
		ST_FULL       = 3'd1,
		ST_POPPED     = 3'd2,
		ST_POP_EMPTY  = 3'd3,
		ST_LISTED     = 3'd4,
		ST_LIST_EMPTY = 3'd5,
		ST_FOUND      = 3'd6,
		ST_NOT_FOUND  = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_SCAN,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic          wr_en;
		logic [AW-1:0] wr_addr;
		logic          rd_en;
		logic [AW-1:0] rd_addr;
	} ram_ctl_t;

endpackage
`default_nettype wire

FILE: src/bss_req_if.sv
// request channel: operation and value
`default_nettype none
interface bss_req_if;
	import bss_pkg::*;

	logic                     valid;
	logic                     ready;
	op_t                      op;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, output op, output value, input ready);
	modport sink   (input valid, input op, input value, output ready);
endinterface
`default_nettype wire

FILE: src/bss_rsp_if.sv
// response channel: status, data, position and last flag
`default_nettype none
interface bss_rsp_if;
	import bss_pkg::*;

	logic                     valid;
	logic                     ready;
	status_t                  status;
	logic signed [DATA_W-1:0] data;
	logic [POS_W-1:0]         position;
	logic                     last;

	modport source (output valid, output status, output data, output position, output last,
		input ready);
	modport sink   (input valid, input status, input data, input position, input last,
		output ready);
endinterface
`default_nettype wire

FILE: src/bss_ram.sv
// entry store: one write port, one registered read port
`default_nettype none
module bss_ram (
	input  wire                           clk,
	input  wire bss_pkg::ram_ctl_t        ctl,
	input  wire  [bss_pkg::DATA_W-1:0]    wdata,
	output logic [bss_pkg::DATA_W-1:0]    rdata
);
	import bss_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[ctl.wr_addr] <= wdata;
		end
		if (ctl.rd_en) begin
			rdata <= mem[ctl.rd_addr];
		end
	end
endmodule
`default_nettype wire

FILE: src/bounded_stack_with_search.sv
// bounded lifo stack of signed words with list and search
// usage:
//   req carries one request word (op, value); rsp carries result words
//   (status, data, position, last). both use valid/ready, a word moves when
//   both are high. every request ends with exactly one word that has last set.
// timing:
//   a request is taken only while no earlier request is in progress and the
//   response register is free or being emptied in the same cycle.
//   push, and any request on an empty stack: the result is registered on
//   accept and shown in the next cycle, in which the next request may follow.
//   pop: the entry is read into the store's read register, then loaded into
//   the response register once that is free.
//   list and search: the entries are read from the store one per cycle, the
//   store's read port sets the pace, unless the response channel stalls the
//   walk. listed words appear one per cycle while rsp.ready stays high.
//   search holds back one found word so that the final one can carry last.
// stalls:
//   a response word waiting on rsp.ready halts a list walk with the read data
//   held, a search walk only at a further match; nothing is dropped or repeated.
// reset:
//   arst_n empties the stack and clears the handshake state; stored entries
//   are not cleared and are only read after they have been written.
`default_nettype none
module bounded_stack_with_search (
	input wire        clk,
	input wire        arst_n,
	bss_req_if.sink   req,
	bss_rsp_if.source rsp
);
	import bss_pkg::*;

	state_t                   state_q, state_d;
	logic [CW-1:0]            fill_q, fill_d;
	op_t                      op_q, op_d;
	logic signed [DATA_W-1:0] key_q, key_d;
	logic [CW-1:0]            idx_q, idx_d;
	logic                     v_s1, v_s1_d;
	logic [AW-1:0]            idx_s1, idx_s1_d;
	logic                     pend_v_q, pend_v_d;
	logic [AW-1:0]            pend_idx_q, pend_idx_d;

	logic                     out_v_q;
	status_t                  out_status_q;
	logic signed [DATA_W-1:0] out_data_q;
	logic [POS_W-1:0]         out_pos_q;
	logic                     out_last_q;

	logic                     load_out;
	status_t                  ld_status;
	logic signed [DATA_W-1:0] ld_data;
	logic [POS_W-1:0]         ld_pos;
	logic                     ld_last;

	ram_ctl_t                 ram_ctl;
	logic [DATA_W-1:0]        rdata;
	logic                     out_free;
	logic                     accept;
	logic                     consume;
	logic                     issue;

	bss_ram u_ram (
		.clk   (clk),
		.ctl   (ram_ctl),
		.wdata (req.value),
		.rdata (rdata)
	);

	assign out_free  = !out_v_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;
	assign accept    = req.valid && req.ready;

	always_comb begin
		state_d    = state_q;
		fill_d     = fill_q;
		op_d       = op_q;
		key_d      = key_q;
		idx_d      = idx_q;
		v_s1_d     = v_s1;
		idx_s1_d   = idx_s1;
		pend_v_d   = pend_v_q;
		pend_idx_d = pend_idx_q;
		load_out   = 1'b0;
		ld_status  = ST_PUSHED;
		ld_data    = '0;
		ld_pos     = '0;
		ld_last    = 1'b1;
		ram_ctl    = '0;
		consume    = 1'b0;
		issue      = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_d     = req.op;
					key_d    = req.value;
					idx_d    = '0;
					v_s1_d   = 1'b0;
					pend_v_d = 1'b0;
					unique case (req.op)
						OP_PUSH: begin
							load_out = 1'b1;
							if (fill_q == CW'(DEPTH)) begin
								ld_status = ST_FULL;
							end else begin
								ram_ctl.wr_en   = 1'b1;
								ram_ctl.wr_addr = fill_q[AW-1:0];
								fill_d          = fill_q + CW'(1);
								ld_status       = ST_PUSHED;
							end
						end
						OP_POP: begin
							if (fill_q == '0) begin
								load_out  = 1'b1;
								ld_status = ST_POP_EMPTY;
							end else begin
								ram_ctl.rd_en   = 1'b1;
								ram_ctl.rd_addr = AW'(fill_q - CW'(1));
								fill_d          = fill_q - CW'(1);
								state_d         = S_POP;
							end
						end
						OP_LIST: begin
							if (fill_q == '0) begin
								load_out  = 1'b1;
								ld_status = ST_LIST_EMPTY;
							end else begin
								state_d = S_SCAN;
							end
						end
						default: begin
							if (fill_q == '0) begin
								load_out  = 1'b1;
								ld_status = ST_NOT_FOUND;
							end else begin
								state_d = S_SCAN;
							end
						end
					endcase
				end
			end
			S_POP: begin
				if (out_free) begin
					load_out  = 1'b1;
					ld_status = ST_POPPED;
					ld_data   = rdata;
					state_d   = S_IDLE;
				end
			end
			S_SCAN: begin
				if (v_s1) begin
					if (op_q == OP_LIST) begin
						consume = out_free;
						if (out_free) begin
							load_out  = 1'b1;
							ld_status = ST_LISTED;
							ld_data   = rdata;
							ld_pos    = POS_W'(idx_s1);
							ld_last   = (CW'(idx_s1) + CW'(1)) == fill_q;
						end
					end else if (rdata != key_q) begin
						consume = 1'b1;
					end else if (!pend_v_q) begin
						consume    = 1'b1;
						pend_v_d   = 1'b1;
						pend_idx_d = idx_s1;
					end else if (out_free) begin
						// an earlier match goes out now, a later one exists
						consume    = 1'b1;
						load_out   = 1'b1;
						ld_status  = ST_FOUND;
						ld_pos     = POS_W'(pend_idx_q);
						ld_last    = 1'b0;
						pend_idx_d = idx_s1;
					end
				end
				issue = (idx_q < fill_q) && (!v_s1 || consume);
				if (issue) begin
					ram_ctl.rd_en   = 1'b1;
					ram_ctl.rd_addr = idx_q[AW-1:0];
					idx_d           = idx_q + CW'(1);
					v_s1_d          = 1'b1;
					idx_s1_d        = idx_q[AW-1:0];
				end else if (consume) begin
					v_s1_d = 1'b0;
					if (idx_q == fill_q) begin
						state_d = (op_q == OP_LIST) ? S_IDLE : S_FINISH;
					end
				end
			end
			S_FINISH: begin
				if (out_free) begin
					load_out  = 1'b1;
					ld_status = pend_v_q ? ST_FOUND : ST_NOT_FOUND;
					ld_pos    = pend_v_q ? POS_W'(pend_idx_q) : '0;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			fill_q   <= '0;
			v_s1     <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			fill_q   <= fill_d;
			v_s1     <= v_s1_d;
			pend_v_q <= pend_v_d;
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		op_q       <= op_d;
		key_q      <= key_d;
		idx_q      <= idx_d;
		idx_s1     <= idx_s1_d;
		pend_idx_q <= pend_idx_d;
		if (load_out) begin
			out_status_q <= ld_status;
			out_data_q   <= ld_data;
			out_pos_q    <= ld_pos;
			out_last_q   <= ld_last;
		end
	end

	assign rsp.valid    = out_v_q;
	assign rsp.status   = out_status_q;
	assign rsp.data     = out_data_q;
	assign rsp.position = out_pos_q;
	assign rsp.last     = out_last_q;
endmodule
`default_nettype wire

FILE: src/bss_checker.sv
// port-level checks of the stack's response channel, bound to the top level
`default_nettype none
module bss_checker (
	input wire                         clk,
	input wire                         arst_n,
	input wire                         rsp_valid,
	input wire                         rsp_ready,
	input wire [2:0]                   rsp_status,
	input wire [bss_pkg::DATA_W-1:0]   rsp_data,
	input wire [bss_pkg::POS_W-1:0]    rsp_position,
	input wire                         rsp_last
);
	import bss_pkg::*;

	// a stalled word holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_data)
			&& $stable(rsp_position) && $stable(rsp_last))
		else $error("response word changed under stall");

	// single-result outcomes always close their request
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == ST_PUSHED || rsp_status == ST_FULL
			|| rsp_status == ST_POPPED || rsp_status == ST_POP_EMPTY
			|| rsp_status == ST_LIST_EMPTY || rsp_status == ST_NOT_FOUND) |-> rsp_last)
		else $error("single result without last");

	// data only for popped and listed words
	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_POPPED && rsp_status != ST_LISTED |-> rsp_data == '0)
		else $error("data set on a word that carries none");

	// position only for listed and found words
	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_LISTED && rsp_status != ST_FOUND
			|-> rsp_position == '0)
		else $error("position set on a word that carries none");
endmodule

bind bounded_stack_with_search bss_checker u_bss_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_status   (rsp.status),
	.rsp_data     (rsp.data),
	.rsp_position (rsp.position),
	.rsp_last     (rsp.last)
);
`default_nettype wire
